@@ design/dtmq_pkg.sv @@
// Shared types and constants for the deadline timer message queue.
`timescale 1ns / 1ps
package dtmq_pkg;

  localparam logic [2:0] OP_ADD_MSG = 3'd0;
  localparam logic [2:0] OP_ADD_TMR = 3'd1;
  localparam logic [2:0] OP_ADD_DLY = 3'd2;
  localparam logic [2:0] OP_GET     = 3'd3;
  localparam logic [2:0] OP_RM      = 3'd4;
  localparam logic [2:0] OP_RM_ALL  = 3'd5;

  localparam logic [1:0] MODE_MSGS   = 2'd0;
  localparam logic [1:0] MODE_TIMERS = 2'd1;
  localparam logic [1:0] MODE_BOTH   = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RET  = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  localparam logic [2:0] CELL_HOLD  = 3'd0;
  localparam logic [2:0] CELL_LOAD  = 3'd1;
  localparam logic [2:0] CELL_PREV  = 3'd2;
  localparam logic [2:0] CELL_NEXT  = 3'd3;
  localparam logic [2:0] CELL_CLEAR = 3'd4;

  localparam logic [19:0] ANTICIP_RESET = 20'd550;
  localparam logic [9:0]  US_PER_MS     = 10'd1000;
  localparam logic [9:0]  LATE_MAX      = 10'd1000;
  localparam logic [19:0] LATE_CLIP     = 20'd1001000;
  localparam logic [20:0] LATE_RECIP    = 21'd1073742;
  localparam int          LATE_SHIFT    = 30;
  localparam logic [39:0] TIME_MAX      = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  get_mode;
    logic [39:0] now_us;
    logic [31:0] delay_ms;
    logic [15:0] msg_class;
    logic [15:0] msg_type;
    logic [15:0] dest_id;
    logic [31:0] dest_serial;
    logic [31:0] payload;
    logic        class_any;
    logic        type_any;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  count;
    logic [5:0]  removed_count;
    logic        was_timer;
    logic [15:0] out_class;
    logic [15:0] out_type;
    logic [15:0] out_dest_id;
    logic [31:0] out_dest_serial;
    logic [31:0] out_payload;
    logic [31:0] out_serial;
    logic [9:0]  lateness_ms;
  } result_t;

  typedef struct packed {
    logic [39:0] deadline;
    logic [15:0] cls;
    logic [15:0] typ;
    logic [15:0] dst;
    logic [31:0] dser;
    logic [31:0] data;
    logic [31:0] serial;
    logic        delayed;
  } entry_t;

  typedef struct packed {
    logic [39:0] deadline;
    logic [15:0] cls;
    logic [15:0] typ;
    logic [15:0] dst;
    logic        class_any;
    logic        type_any;
  } key_t;

  typedef struct packed {
    logic [2:0] op;
  } cell_ctl_t;

endpackage

@@ design/deadline_timer_message_queue.sv @@
// Top level: sorted timer row, message row and the command sequencer.
//
//   transfer    ports                        when
//   command     start, busy, cmd             edge with start high and busy low
//   result      done, result                 the one cycle that done is high
//   register    cfg_wr_en, cfg_wr_data       edge with cfg_wr_en high
//
// An add message, a full store, remove all or an unused opcode end in the calculate
// state; a stored add timer takes the insert state. A get that checks timers moves
// due delayed messages in the drain state, then the lateness state for a returned
// timer or the pop state, skipped by a timers-only get finding none; other gets pop.
// Remove matching drops matching messages, then timers; busy is high from acceptance
// until the result cycle. Reset empties both rows; the receiver cannot stall.
`timescale 1ns / 1ps
module deadline_timer_message_queue #(
  parameter int TIMER_DEPTH = 16,
  parameter int MSG_DEPTH   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dtmq_pkg::cmd_t    cmd,
  output logic              done,
  output dtmq_pkg::result_t result,
  input  logic              cfg_wr_en,
  input  logic [19:0]       cfg_wr_data
);

  localparam int TCW = $clog2(TIMER_DEPTH + 1);
  localparam int FCW = $clog2(MSG_DEPTH + 1);
  localparam int RCW = $clog2(TIMER_DEPTH + MSG_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CALC  = 4'd1;
  localparam logic [3:0] S_INS   = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_LATE  = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_RMF   = 4'd6;
  localparam logic [3:0] S_RMT   = 4'd7;

  logic [3:0]     state;
  logic [TCW-1:0] tcount;
  logic [FCW-1:0] fcount;
  logic [RCW-1:0] removed;
  logic [31:0]    serial;
  logic [31:0]    serial_next;
  logic [19:0]    anticipation;
  dtmq_pkg::cmd_t req;
  logic [39:0]    dl;
  logic [40:0]    nowa;
  logic [19:0]    late_x;

  dtmq_pkg::entry_t    t_entry [TIMER_DEPTH];
  dtmq_pkg::entry_t    t_prev_e [TIMER_DEPTH];
  dtmq_pkg::entry_t    t_next_e [TIMER_DEPTH];
  logic                t_valid [TIMER_DEPTH];
  logic                t_prev_v [TIMER_DEPTH];
  logic                t_next_v [TIMER_DEPTH];
  logic                t_later [TIMER_DEPTH];
  logic                t_hit [TIMER_DEPTH];
  logic                t_after [TIMER_DEPTH];
  logic                t_pre [TIMER_DEPTH];
  dtmq_pkg::cell_ctl_t t_ctl [TIMER_DEPTH];

  dtmq_pkg::entry_t    f_entry [MSG_DEPTH];
  dtmq_pkg::entry_t    f_prev_e [MSG_DEPTH];
  dtmq_pkg::entry_t    f_next_e [MSG_DEPTH];
  logic                f_valid [MSG_DEPTH];
  logic                f_prev_v [MSG_DEPTH];
  logic                f_next_v [MSG_DEPTH];
  logic                f_later [MSG_DEPTH];
  logic                f_hit [MSG_DEPTH];
  logic                f_pre [MSG_DEPTH];
  dtmq_pkg::cell_ctl_t f_ctl [MSG_DEPTH];

  dtmq_pkg::key_t   key;
  dtmq_pkg::entry_t new_entry;
  dtmq_pkg::entry_t fifo_load;
  logic             t_empty, t_full, f_empty, f_full;
  logic             head_due, push_ok, ret_timer;
  logic [41:0]      dprod;
  logic [42:0]      dsum;
  logic [39:0]      diff;
  logic [40:0]      lprod;
  logic [10:0]      lq;

  assign busy = (state != S_IDLE);

  assign serial_next = (serial == 32'hFFFF_FFFF) ? 32'd1 : serial + 32'd1;

  assign t_empty = (tcount == '0);
  assign t_full  = (tcount == TCW'(TIMER_DEPTH));
  assign f_empty = (fcount == '0);
  assign f_full  = (fcount == FCW'(MSG_DEPTH));

  assign head_due  = !t_empty && ({1'b0, t_entry[0].deadline} <= nowa);
  assign push_ok   = head_due && t_entry[0].delayed && !f_full;
  assign ret_timer = head_due && !t_entry[0].delayed;

  assign dprod = 42'(req.delay_ms) * 42'(dtmq_pkg::US_PER_MS);
  assign dsum  = 43'(req.now_us) + 43'(dprod);
  assign diff  = req.now_us - t_entry[0].deadline;
  assign lprod = 41'(late_x) * 41'(dtmq_pkg::LATE_RECIP);
  assign lq    = lprod[40:dtmq_pkg::LATE_SHIFT];

  assign key.deadline  = dl;
  assign key.cls       = req.msg_class;
  assign key.typ       = req.msg_type;
  assign key.dst       = req.dest_id;
  assign key.class_any = req.class_any;
  assign key.type_any  = req.type_any;

  assign new_entry.deadline = dl;
  assign new_entry.cls      = req.msg_class;
  assign new_entry.typ      = req.msg_type;
  assign new_entry.dst      = req.dest_id;
  assign new_entry.dser     = req.dest_serial;
  assign new_entry.data     = req.payload;
  assign new_entry.serial   = serial_next;
  assign new_entry.delayed  = (req.opcode == dtmq_pkg::OP_ADD_DLY);

  always_comb begin
    fifo_load = new_entry;
    if (state == S_DRAIN) begin
      fifo_load        = t_entry[0];
      fifo_load.serial = serial_next;
    end
  end

  genvar g;
  generate
    for (g = 0; g < TIMER_DEPTH; g++) begin : g_tcell
      if (g == 0) begin : g_first
        assign t_prev_e[g] = '0;
        assign t_prev_v[g] = 1'b0;
      end else begin : g_mid
        assign t_prev_e[g] = t_entry[g-1];
        assign t_prev_v[g] = t_valid[g-1];
      end
      if (g == TIMER_DEPTH - 1) begin : g_last
        assign t_next_e[g] = '0;
        assign t_next_v[g] = 1'b0;
      end else begin : g_inner
        assign t_next_e[g] = t_entry[g+1];
        assign t_next_v[g] = t_valid[g+1];
      end
      assign t_after[g] = !t_valid[g] || t_later[g];
      dtmq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (t_ctl[g]),
        .load_entry (new_entry),
        .prev_entry (t_prev_e[g]),
        .prev_valid (t_prev_v[g]),
        .next_entry (t_next_e[g]),
        .next_valid (t_next_v[g]),
        .key        (key),
        .entry      (t_entry[g]),
        .valid      (t_valid[g]),
        .later      (t_later[g]),
        .hit        (t_hit[g])
      );
    end
    for (g = 0; g < MSG_DEPTH; g++) begin : g_fcell
      if (g == 0) begin : g_first
        assign f_prev_e[g] = '0;
        assign f_prev_v[g] = 1'b0;
      end else begin : g_mid
        assign f_prev_e[g] = f_entry[g-1];
        assign f_prev_v[g] = f_valid[g-1];
      end
      if (g == MSG_DEPTH - 1) begin : g_last
        assign f_next_e[g] = '0;
        assign f_next_v[g] = 1'b0;
      end else begin : g_inner
        assign f_next_e[g] = f_entry[g+1];
        assign f_next_v[g] = f_valid[g+1];
      end
      dtmq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (f_ctl[g]),
        .load_entry (fifo_load),
        .prev_entry (f_prev_e[g]),
        .prev_valid (f_prev_v[g]),
        .next_entry (f_next_e[g]),
        .next_valid (f_next_v[g]),
        .key        (key),
        .entry      (f_entry[g]),
        .valid      (f_valid[g]),
        .later      (f_later[g]),
        .hit        (f_hit[g])
      );
    end
  endgenerate

  always_comb begin
    t_pre[0] = t_hit[0];
    for (int i = 1; i < TIMER_DEPTH; i++) begin
      t_pre[i] = t_pre[i-1] || t_hit[i];
    end
    f_pre[0] = f_hit[0];
    for (int i = 1; i < MSG_DEPTH; i++) begin
      f_pre[i] = f_pre[i-1] || f_hit[i];
    end
  end

  always_comb begin
    for (int i = 0; i < TIMER_DEPTH; i++) begin
      t_ctl[i].op = dtmq_pkg::CELL_HOLD;
      unique case (state)
        S_CALC: begin
          if (req.opcode == dtmq_pkg::OP_RM_ALL) t_ctl[i].op = dtmq_pkg::CELL_CLEAR;
        end
        S_INS: begin
          if (t_after[i]) begin
            if (i == 0) t_ctl[i].op = dtmq_pkg::CELL_LOAD;
            else if (!t_after[(i == 0) ? 0 : i - 1]) t_ctl[i].op = dtmq_pkg::CELL_LOAD;
            else t_ctl[i].op = dtmq_pkg::CELL_PREV;
          end
        end
        S_DRAIN: begin
          if (push_ok || ret_timer) t_ctl[i].op = dtmq_pkg::CELL_NEXT;
        end
        S_RMT: begin
          if (t_pre[i]) t_ctl[i].op = dtmq_pkg::CELL_NEXT;
        end
        default: t_ctl[i].op = dtmq_pkg::CELL_HOLD;
      endcase
    end
    for (int i = 0; i < MSG_DEPTH; i++) begin
      f_ctl[i].op = dtmq_pkg::CELL_HOLD;
      unique case (state)
        S_CALC: begin
          if (req.opcode == dtmq_pkg::OP_RM_ALL) begin
            f_ctl[i].op = dtmq_pkg::CELL_CLEAR;
          end else if (req.opcode == dtmq_pkg::OP_ADD_MSG && !f_full &&
                       fcount == FCW'(i)) begin
            f_ctl[i].op = dtmq_pkg::CELL_LOAD;
          end
        end
        S_DRAIN: begin
          if (push_ok && fcount == FCW'(i)) f_ctl[i].op = dtmq_pkg::CELL_LOAD;
        end
        S_POP: begin
          if (!f_empty) f_ctl[i].op = dtmq_pkg::CELL_NEXT;
        end
        S_RMF: begin
          if (f_pre[i]) f_ctl[i].op = dtmq_pkg::CELL_NEXT;
        end
        default: f_ctl[i].op = dtmq_pkg::CELL_HOLD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anticipation <= dtmq_pkg::ANTICIP_RESET;
    end else if (cfg_wr_en) begin
      anticipation <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tcount  <= '0;
      fcount  <= '0;
      removed <= '0;
      serial  <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_CALC;
        end
        S_CALC: begin
          unique case (req.opcode)
            dtmq_pkg::OP_ADD_MSG: begin
              if (!f_full) begin
                fcount <= fcount + FCW'(1);
                serial <= serial_next;
              end
              state <= S_IDLE;
              done  <= 1'b1;
            end
            dtmq_pkg::OP_ADD_TMR, dtmq_pkg::OP_ADD_DLY: begin
              if (t_full) begin
                state <= S_IDLE;
                done  <= 1'b1;
              end else begin
                state <= S_INS;
              end
            end
            dtmq_pkg::OP_GET: begin
              if (req.get_mode == dtmq_pkg::MODE_TIMERS ||
                  req.get_mode == dtmq_pkg::MODE_BOTH) state <= S_DRAIN;
              else state <= S_POP;
            end
            dtmq_pkg::OP_RM: begin
              removed <= '0;
              state   <= S_RMF;
            end
            dtmq_pkg::OP_RM_ALL: begin
              fcount <= '0;
              tcount <= '0;
              state  <= S_IDLE;
              done   <= 1'b1;
            end
            default: begin
              state <= S_IDLE;
              done  <= 1'b1;
            end
          endcase
        end
        S_INS: begin
          tcount <= tcount + TCW'(1);
          serial <= serial_next;
          state  <= S_IDLE;
          done   <= 1'b1;
        end
        S_DRAIN: begin
          if (push_ok) begin
            fcount <= fcount + FCW'(1);
            tcount <= tcount - TCW'(1);
            serial <= serial_next;
          end else if (ret_timer) begin
            tcount <= tcount - TCW'(1);
            state  <= S_LATE;
          end else if (req.get_mode == dtmq_pkg::MODE_TIMERS) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_POP;
          end
        end
        S_LATE: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_POP: begin
          if (!f_empty) fcount <= fcount - FCW'(1);
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_RMF: begin
          if (f_pre[MSG_DEPTH-1]) begin
            fcount  <= fcount - FCW'(1);
            removed <= removed + RCW'(1);
          end else begin
            state <= S_RMT;
          end
        end
        S_RMT: begin
          if (t_pre[TIMER_DEPTH-1]) begin
            tcount  <= tcount - TCW'(1);
            removed <= removed + RCW'(1);
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start && !busy) begin
          req    <= cmd;
          result <= '0;
        end
      end
      S_CALC: begin
        dl   <= (dsum[42:40] != 3'd0) ? dtmq_pkg::TIME_MAX : dsum[39:0];
        nowa <= 41'(req.now_us) + 41'(anticipation);
        unique case (req.opcode)
          dtmq_pkg::OP_ADD_MSG: begin
            if (f_full) begin
              result.status <= dtmq_pkg::ST_FULL;
              result.count  <= 5'(fcount);
            end else begin
              result.count <= 5'(fcount + FCW'(1));
            end
          end
          dtmq_pkg::OP_ADD_TMR, dtmq_pkg::OP_ADD_DLY: begin
            if (t_full) begin
              result.status <= dtmq_pkg::ST_FULL;
              result.count  <= 5'(tcount);
            end
          end
          dtmq_pkg::OP_RM_ALL: begin
            result.removed_count <= 6'(RCW'(fcount) + RCW'(tcount));
          end
          default: result <= result;
        endcase
      end
      S_INS: begin
        result.count <= 5'(tcount + TCW'(1));
      end
      S_DRAIN: begin
        if (!push_ok && ret_timer) begin
          result.status          <= dtmq_pkg::ST_RET;
          result.was_timer       <= 1'b1;
          result.out_class       <= t_entry[0].cls;
          result.out_type        <= t_entry[0].typ;
          result.out_dest_id     <= t_entry[0].dst;
          result.out_dest_serial <= t_entry[0].dser;
          result.out_payload     <= t_entry[0].data;
          result.out_serial      <= t_entry[0].serial;
          if (req.now_us > t_entry[0].deadline) begin
            late_x <= (diff >= 40'(dtmq_pkg::LATE_CLIP)) ? dtmq_pkg::LATE_CLIP : diff[19:0];
          end else begin
            late_x <= '0;
          end
        end else if (!push_ok && req.get_mode == dtmq_pkg::MODE_TIMERS) begin
          result.status <= dtmq_pkg::ST_NONE;
        end
      end
      S_LATE: begin
        result.lateness_ms <= (lq > 11'(dtmq_pkg::LATE_MAX)) ? dtmq_pkg::LATE_MAX : lq[9:0];
      end
      S_POP: begin
        if (f_empty) begin
          result.status <= dtmq_pkg::ST_NONE;
        end else begin
          result.status          <= dtmq_pkg::ST_RET;
          result.out_class       <= f_entry[0].cls;
          result.out_type        <= f_entry[0].typ;
          result.out_dest_id     <= f_entry[0].dst;
          result.out_dest_serial <= f_entry[0].dser;
          result.out_payload     <= f_entry[0].data;
          result.out_serial      <= f_entry[0].serial;
        end
      end
      S_RMT: begin
        if (!t_pre[TIMER_DEPTH-1]) result.removed_count <= 6'(removed);
      end
      default: result <= result;
    endcase
  end

  // The strobe only ever comes with the sequencer back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_tcount_range: assert property (@(posedge clk) disable iff (rst)
    tcount <= TCW'(TIMER_DEPTH))
    else $error("timer count out of range");

  a_fcount_range: assert property (@(posedge clk) disable iff (rst)
    fcount <= FCW'(MSG_DEPTH))
    else $error("message count out of range");

  a_serial_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == dtmq_pkg::ST_RET) |-> (result.out_serial != 32'd0))
    else $error("returned entry has serial zero");

  a_late_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.lateness_ms <= dtmq_pkg::LATE_MAX))
    else $error("lateness above saturation");

endmodule

@@ design/dtmq_cell.sv @@
// One storage cell of a shifting entry row, with its deadline compare and match logic.
`timescale 1ns / 1ps
module dtmq_cell (
  input  logic                clk,
  input  logic                rst,
  input  dtmq_pkg::cell_ctl_t ctl,
  input  dtmq_pkg::entry_t    load_entry,
  input  dtmq_pkg::entry_t    prev_entry,
  input  logic                prev_valid,
  input  dtmq_pkg::entry_t    next_entry,
  input  logic                next_valid,
  input  dtmq_pkg::key_t      key,
  output dtmq_pkg::entry_t    entry,
  output logic                valid,
  output logic                later,
  output logic                hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctl.op)
        dtmq_pkg::CELL_HOLD:  valid <= valid;
        dtmq_pkg::CELL_LOAD:  valid <= 1'b1;
        dtmq_pkg::CELL_PREV:  valid <= prev_valid;
        dtmq_pkg::CELL_NEXT:  valid <= next_valid;
        dtmq_pkg::CELL_CLEAR: valid <= 1'b0;
        default:              valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      dtmq_pkg::CELL_LOAD: entry <= load_entry;
      dtmq_pkg::CELL_PREV: entry <= prev_entry;
      dtmq_pkg::CELL_NEXT: entry <= next_entry;
      default:             entry <= entry;
    endcase
  end

  assign later = valid && (entry.deadline > key.deadline);
  assign hit   = valid && (entry.dst == key.dst) &&
                 (key.class_any || (entry.cls == key.cls)) &&
                 (key.type_any || (entry.typ == key.typ));

endmodule

@@ tb/tb_deadline_timer_message_queue.sv @@
// Testbench for the deadline timer message queue: directed and random commands checked against a predictor.
`timescale 1ns / 1ps
module tb_deadline_timer_message_queue;

  localparam int TDEPTH = 16;
  localparam int MDEPTH = 16;
  localparam logic [39:0] TMASK = 40'hFF_FFFF_FFFF;

  typedef struct {
    logic [39:0] deadline;
    logic [15:0] cls;
    logic [15:0] typ;
    logic [15:0] dst;
    logic [31:0] dser;
    logic [31:0] data;
    logic [31:0] serial;
    bit          delayed;
  } qentry_t;

  class queue_scoreboard;
    qentry_t timers[$];
    qentry_t msgs[$];
    logic [31:0] serial_ctr;
    logic [19:0] anticip;
    dtmq_pkg::result_t expected[$];
    int errors;

    function void clear();
      timers.delete();
      msgs.delete();
      serial_ctr = '0;
      anticip = dtmq_pkg::ANTICIP_RESET;
      expected.delete();
      errors = 0;
    endfunction

    function logic [31:0] bump_serial();
      serial_ctr++;
      if (serial_ctr == 0) serial_ctr++;
      return serial_ctr;
    endfunction

    function bit hit(qentry_t e, dtmq_pkg::cmd_t c);
      return e.dst == c.dest_id && (c.class_any || e.cls == c.msg_class) &&
             (c.type_any || e.typ == c.msg_type);
    endfunction

    function void put(ref dtmq_pkg::result_t r, input qentry_t e);
      r.out_class = e.cls;
      r.out_type = e.typ;
      r.out_dest_id = e.dst;
      r.out_dest_serial = e.dser;
      r.out_payload = e.data;
      r.out_serial = e.serial;
    endfunction

    function void note_command(dtmq_pkg::cmd_t c);
      dtmq_pkg::result_t r;
      qentry_t e;
      logic [41:0] sum;
      logic [63:0] dl;
      logic [39:0] late;
      int pos, removed;
      bit got;
      r = '0;
      e.cls = c.msg_class;
      e.typ = c.msg_type;
      e.dst = c.dest_id;
      e.dser = c.dest_serial;
      e.data = c.payload;
      e.delayed = (c.opcode == dtmq_pkg::OP_ADD_DLY);
      e.deadline = '0;
      got = 0;
      case (c.opcode)
        dtmq_pkg::OP_ADD_MSG: begin
          if (msgs.size() >= MDEPTH) r.status = dtmq_pkg::ST_FULL;
          else begin
            e.serial = bump_serial();
            msgs.push_back(e);
          end
          r.count = 5'(msgs.size());
        end
        dtmq_pkg::OP_ADD_TMR, dtmq_pkg::OP_ADD_DLY: begin
          if (timers.size() >= TDEPTH) begin
            r.status = dtmq_pkg::ST_FULL;
            r.count = 5'(timers.size());
          end else begin
            dl = 64'(c.now_us) + 64'(c.delay_ms) * 64'd1000;
            e.deadline = (dl > 64'(TMASK)) ? TMASK : dl[39:0];
            pos = timers.size();
            foreach (timers[i])
              if (timers[i].deadline > e.deadline && pos == timers.size()) pos = i;
            e.serial = bump_serial();
            timers.insert(pos, e);
            r.count = 5'(timers.size());
          end
        end
        dtmq_pkg::OP_GET: begin
          if (c.get_mode == dtmq_pkg::MODE_TIMERS || c.get_mode == dtmq_pkg::MODE_BOTH) begin
            while (timers.size() > 0) begin
              sum = 42'(c.now_us) + 42'(anticip);
              if (sum < 42'(timers[0].deadline)) break;
              if (timers[0].delayed) begin
                if (msgs.size() >= MDEPTH) break;
                e = timers.pop_front();
                e.serial = bump_serial();
                msgs.push_back(e);
              end else begin
                e = timers.pop_front();
                r.status = dtmq_pkg::ST_RET;
                r.was_timer = 1;
                put(r, e);
                if (c.now_us > e.deadline) begin
                  late = (c.now_us - e.deadline) / 40'd1000;
                  r.lateness_ms = (late > 40'd1000) ? 10'd1000 : late[9:0];
                end
                got = 1;
                break;
              end
            end
            if (!got && c.get_mode == dtmq_pkg::MODE_TIMERS) begin
              r.status = dtmq_pkg::ST_NONE;
              got = 1;
            end
          end
          if (!got) begin
            if (msgs.size() == 0) r.status = dtmq_pkg::ST_NONE;
            else begin
              r.status = dtmq_pkg::ST_RET;
              put(r, msgs.pop_front());
            end
          end
        end
        dtmq_pkg::OP_RM: begin
          removed = 0;
          for (int i = msgs.size() - 1; i >= 0; i--)
            if (hit(msgs[i], c)) begin
              msgs.delete(i);
              removed++;
            end
          for (int i = timers.size() - 1; i >= 0; i--)
            if (hit(timers[i], c)) begin
              timers.delete(i);
              removed++;
            end
          r.removed_count = 6'(removed);
        end
        dtmq_pkg::OP_RM_ALL: begin
          r.removed_count = 6'(msgs.size() + timers.size());
          msgs.delete();
          timers.delete();
        end
        default: ;
      endcase
      expected.push_back(r);
    endfunction

    function void check_result(dtmq_pkg::result_t got_r);
      dtmq_pkg::result_t w;
      if (expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got_r);
        errors++;
        return;
      end
      w = expected.pop_front();
      if (got_r !== w) begin
        $display("%0t: mismatch expected %h actual %h", $time, w, got_r);
        if (got_r.status !== w.status)
          $display("%0t:   status expected %0d actual %0d", $time, w.status, got_r.status);
        if (got_r.out_serial !== w.out_serial)
          $display("%0t:   serial expected %0d actual %0d", $time, w.out_serial,
                   got_r.out_serial);
        if (got_r.lateness_ms !== w.lateness_ms)
          $display("%0t:   lateness expected %0d actual %0d", $time, w.lateness_ms,
                   got_r.lateness_ms);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, cfg_wr_en;
  dtmq_pkg::cmd_t cmd;
  dtmq_pkg::result_t result;
  logic [19:0] cfg_wr_data;
  logic [39:0] now;
  queue_scoreboard sb;

  deadline_timer_message_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("** deadline_timer_message_queue: FAILED **");
    $finish;
  end

  always @(posedge clk)
    if (!rst && done) sb.check_result(result);

  task automatic issue(dtmq_pkg::cmd_t c);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.note_command(c);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_anticip(logic [19:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.anticip = v;
  endtask

  function automatic dtmq_pkg::cmd_t make_cmd(logic [2:0] op, bit narrow);
    dtmq_pkg::cmd_t c;
    c = '0;
    c.opcode = op;
    c.get_mode = 2'($urandom_range(0, 3));
    c.now_us = now;
    case ($urandom_range(0, 9))
      0: c.delay_ms = $urandom;
      1: c.delay_ms = 32'hFFFF_FFFF;
      default: c.delay_ms = 32'($urandom_range(0, 20));
    endcase
    c.msg_class = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
    c.msg_type = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
    c.dest_id = narrow ? 16'($urandom_range(0, 2)) : 16'($urandom);
    c.dest_serial = $urandom;
    c.payload = $urandom;
    c.class_any = 1'($urandom_range(0, 1));
    c.type_any = 1'($urandom_range(0, 1));
    return c;
  endfunction

  initial begin
    dtmq_pkg::cmd_t c;
    int op_pick, burst;
    sb = new();
    sb.clear();
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    now = 40'd1000;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: extremes, full stores, overflowed deadline, odd modes and opcodes.
    for (int i = 0; i < 17; i++) issue(make_cmd(dtmq_pkg::OP_ADD_MSG, 0));
    c = make_cmd(dtmq_pkg::OP_ADD_TMR, 0);
    c.now_us = TMASK;
    c.delay_ms = 32'hFFFF_FFFF;
    c.msg_class = 16'hFFFF;
    c.payload = 32'hFFFF_FFFF;
    issue(c);
    c = make_cmd(dtmq_pkg::OP_ADD_DLY, 0);
    c.delay_ms = '0;
    issue(c);
    c = make_cmd(dtmq_pkg::OP_GET, 0);
    c.get_mode = dtmq_pkg::MODE_BOTH;
    issue(c);
    c.get_mode = 2'd3;
    issue(c);
    c.get_mode = dtmq_pkg::MODE_TIMERS;
    c.now_us = TMASK;
    issue(c);
    issue(make_cmd(3'd6, 0));
    issue(make_cmd(3'd7, 0));
    issue(make_cmd(dtmq_pkg::OP_RM, 1));
    issue(make_cmd(dtmq_pkg::OP_RM_ALL, 0));
    write_anticip(20'd0);
    write_anticip(20'd1000000);
    write_anticip(20'hFFFFF);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_anticip(20'd550);
        1: write_anticip(20'd0);
        2: write_anticip(20'($urandom_range(0, 20000)));
        default: write_anticip(20'd1000000);
      endcase
      for (int n = 0; n < 250; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 250; b++, n++) begin
          now = now + 40'($urandom_range(0, 3000));
          if ($urandom_range(0, 200) == 0) now = 40'($urandom);
          op_pick = $urandom_range(0, 99);
          if (op_pick < 20) c = make_cmd(dtmq_pkg::OP_ADD_MSG, 1);
          else if (op_pick < 40) c = make_cmd(dtmq_pkg::OP_ADD_TMR, 1);
          else if (op_pick < 52) c = make_cmd(dtmq_pkg::OP_ADD_DLY, 1);
          else if (op_pick < 85) c = make_cmd(dtmq_pkg::OP_GET, 1);
          else if (op_pick < 94) c = make_cmd(dtmq_pkg::OP_RM, 1);
          else if (op_pick < 96) c = make_cmd(dtmq_pkg::OP_RM_ALL, 0);
          else if (op_pick < 98) c = make_cmd(3'($urandom_range(0, 7)), 0);
          else c = make_cmd(3'($urandom_range(0, 5)), 0);
          issue(c);
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(posedge clk);
        if (n == 125) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.expected.size() == 0)
      $display("** deadline_timer_message_queue: PASSED **");
    else
      $display("** deadline_timer_message_queue: FAILED **");
    $finish;
  end
endmodule
